// ----- design/domq_pkg.sv -----
package domq_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int DATA_W = 32;
  localparam int TIME_W = 32;
  localparam int STATUS_W = 3;
  localparam int OCC_W = 5;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED  = 3'd0,
    ST_DELIVERED = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_DUE   = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Shift commands broadcast to every cell of the sorted row.
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

// ----- design/domq_cell.sv -----
module domq_cell (
  input  logic                          clk,
  input  domq_pkg::cell_ctrl_t          ctrl,
  input  logic                          valid,
  input  logic [domq_pkg::TIME_W-1:0]   new_deadline,
  input  logic [domq_pkg::DATA_W-1:0]   new_payload,
  input  logic                          left_le,
  input  logic [domq_pkg::TIME_W-1:0]   left_deadline,
  input  logic [domq_pkg::DATA_W-1:0]   left_payload,
  input  logic [domq_pkg::TIME_W-1:0]   right_deadline,
  input  logic [domq_pkg::DATA_W-1:0]   right_payload,
  output logic                          le,
  output logic [domq_pkg::TIME_W-1:0]   deadline,
  output logic [domq_pkg::DATA_W-1:0]   payload
);

  // A cell holding an entry that is due no later than the new one keeps it.
  assign le = valid && (deadline <= new_deadline);

  always_ff @(posedge clk) begin
    priority if (ctrl.insert && !le) begin
      if (left_le) begin
        deadline <= new_deadline;
        payload  <= new_payload;
      end else begin
        deadline <= left_deadline;
        payload  <= left_payload;
      end
    end else if (ctrl.remove) begin
      deadline <= right_deadline;
      payload  <= right_payload;
    end else begin
      deadline <= deadline;
      payload  <= payload;
    end
  end

endmodule

// ----- design/deadline_ordered_message_queue_unit.sv -----
// A result appears on the master side in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle unless stalled; every cell compares its deadline
// with the new one in parallel, so the whole insert or head removal is one register update
// of the cell row. The slave side stalls only while a result waits on the master side.
// Reset clears the entry count and the output valid; the stored deadlines and payloads
// are not cleared, since only entries below the count are ever read.
module deadline_ordered_message_queue_unit #(
  parameter int CAPACITY = domq_pkg::CAPACITY_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // payload[31:0], deadline[63:32], now_time[95:64]
  input  logic         s_tuser,   // operation[0]: 0 enqueue, 1 poll
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata,   // out_payload[31:0], out_deadline[63:32],
                                  // occupancy[68:64], zero fill[71:69]
  output logic [2:0]   m_tuser    // status[2:0]
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [domq_pkg::DATA_W-1:0] in_payload;
  logic [domq_pkg::TIME_W-1:0] in_deadline;
  logic [domq_pkg::TIME_W-1:0] in_now;
  logic                        in_poll;

  assign in_payload  = s_tdata[31:0];
  assign in_deadline = s_tdata[63:32];
  assign in_now      = s_tdata[95:64];
  assign in_poll     = s_tuser;

  // Number of stored entries; cells below it hold the sorted queue.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic [domq_pkg::TIME_W-1:0] cell_deadline [CAPACITY];
  logic [domq_pkg::DATA_W-1:0] cell_payload  [CAPACITY];
  logic [CAPACITY-1:0]         cell_le;
  logic [CAPACITY-1:0]         cell_valid;

  logic accept;
  logic full;
  logic empty;
  logic head_due;
  domq_pkg::cell_ctrl_t ctrl;

  // The slave side moves whenever the output register is free or being drained.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign head_due = !empty && (in_now >= cell_deadline[0]);

  assign ctrl.insert = accept && !in_poll && !full;
  assign ctrl.remove = accept && in_poll && head_due;

  // The row of cells. An insert finds its slot where the "due no later" flag
  // first drops, and everything behind it moves one cell to the right. A removal
  // moves every cell one to the left. The last cell's right input is itself,
  // which is harmless because that slot is beyond the count after a removal.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_valid[i] = (count > CNT_W'(i));

    if (i == 0) begin : g_head
      domq_cell u_cell (
        .clk            (clk),
        .ctrl           (ctrl),
        .valid          (cell_valid[i]),
        .new_deadline   (in_deadline),
        .new_payload    (in_payload),
        .left_le        (1'b1),
        .left_deadline  (in_deadline),
        .left_payload   (in_payload),
        .right_deadline (cell_deadline[(i + 1) % CAPACITY]),
        .right_payload  (cell_payload[(i + 1) % CAPACITY]),
        .le             (cell_le[i]),
        .deadline       (cell_deadline[i]),
        .payload        (cell_payload[i])
      );
    end else if (i == CAPACITY - 1) begin : g_tail
      domq_cell u_cell (
        .clk            (clk),
        .ctrl           (ctrl),
        .valid          (cell_valid[i]),
        .new_deadline   (in_deadline),
        .new_payload    (in_payload),
        .left_le        (cell_le[i-1]),
        .left_deadline  (cell_deadline[i-1]),
        .left_payload   (cell_payload[i-1]),
        .right_deadline (cell_deadline[i]),
        .right_payload  (cell_payload[i]),
        .le             (cell_le[i]),
        .deadline       (cell_deadline[i]),
        .payload        (cell_payload[i])
      );
    end else begin : g_mid
      domq_cell u_cell (
        .clk            (clk),
        .ctrl           (ctrl),
        .valid          (cell_valid[i]),
        .new_deadline   (in_deadline),
        .new_payload    (in_payload),
        .left_le        (cell_le[i-1]),
        .left_deadline  (cell_deadline[i-1]),
        .left_payload   (cell_payload[i-1]),
        .right_deadline (cell_deadline[i+1]),
        .right_payload  (cell_payload[i+1]),
        .le             (cell_le[i]),
        .deadline       (cell_deadline[i]),
        .payload        (cell_payload[i])
      );
    end
  end

  always_comb begin
    count_next = count;
    if (ctrl.insert) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.remove) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result computed at acceptance and held in the output register.
  domq_pkg::status_t           status_next;
  logic [domq_pkg::DATA_W-1:0] res_payload_next;
  logic [domq_pkg::TIME_W-1:0] res_deadline_next;
  logic [31:0]                 count_ext;

  domq_pkg::status_t           status;
  logic [domq_pkg::DATA_W-1:0] res_payload;
  logic [domq_pkg::TIME_W-1:0] res_deadline;
  logic [domq_pkg::OCC_W-1:0]  occupancy;

  assign count_ext = 32'(count_next);

  always_comb begin
    status_next       = domq_pkg::ST_ACCEPTED;
    res_payload_next  = '0;
    res_deadline_next = '0;
    if (!in_poll) begin
      status_next = full ? domq_pkg::ST_FULL : domq_pkg::ST_ACCEPTED;
    end else if (empty) begin
      status_next = domq_pkg::ST_EMPTY;
    end else if (!head_due) begin
      status_next       = domq_pkg::ST_NOT_DUE;
      res_deadline_next = cell_deadline[0];
    end else begin
      status_next       = domq_pkg::ST_DELIVERED;
      res_payload_next  = cell_payload[0];
      res_deadline_next = cell_deadline[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= status_next;
      res_payload  <= res_payload_next;
      res_deadline <= res_deadline_next;
      occupancy    <= count_ext[domq_pkg::OCC_W-1:0];
    end
  end

  assign m_tdata = {3'b000, occupancy, res_deadline, res_payload};
  assign m_tuser = status;

endmodule

// ----- design/domq_checker.sv -----
module domq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [95:0] s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // No result is shown in the cycle after reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Every accepted transaction gives a result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted transaction produced no result");

  // Only a delivery carries a payload.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != domq_pkg::ST_DELIVERED) |-> (m_tdata[31:0] == '0))
    else $error("payload set on a result that is not a delivery");

  // Accepted, empty and full results carry no deadline.
  a_deadline_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == domq_pkg::ST_ACCEPTED) || (m_tuser == domq_pkg::ST_EMPTY) ||
                 (m_tuser == domq_pkg::ST_FULL)) |-> (m_tdata[63:32] == '0))
    else $error("deadline set on a result without a head");

endmodule

bind deadline_ordered_message_queue_unit domq_checker u_domq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
